FILE: hdl/pfds_pkg.sv
package pfds_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam int MUL_W     = 64;
    localparam int MUL_CNT_W = $clog2(MUL_W);
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 48;
    localparam int STEP_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ATT_LIN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT_ANG   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_LIN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_ANG   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_LIMIT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_LIMIT = 4'd7;

    localparam logic [47:0] RST_ATT_LIN   = 48'd109951162777600;
    localparam logic [47:0] RST_ATT_ANG   = 48'd329853488333;
    localparam logic [47:0] RST_REP_LIN   = 48'd55;
    localparam logic [47:0] RST_REP_ANG   = 48'd659706976666;
    localparam logic [31:0] RST_START_X   = 32'd327680;
    localparam logic [31:0] RST_START_Y   = 32'd0;
    localparam logic [30:0] RST_LIN_LIMIT = 31'd6554;
    localparam logic [30:0] RST_ANG_LIMIT = 31'd65536;

    // 99999999999.0 in Q48.16
    localparam logic [63:0] INF_REPEL_Q16 = 64'd6553599999934464;

    localparam logic signed [37:0] PI_Q32      = 38'sd13493037705;
    localparam logic signed [37:0] TWO_PI_Q32  = 38'sd26986075409;
    localparam logic signed [37:0] HALF_PI_Q32 = 38'sd6746518852;
    localparam logic [36:0]        TWO_PI_U    = 37'd26986075409;
    localparam logic [29:0]        INV_GAIN_Q30 = 30'd652032874;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

endpackage

FILE: hdl/pfds_serial_mul.sv
module pfds_serial_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfds_pkg::mul_req_t            req,
    output logic                          done,
    output logic [2*pfds_pkg::MUL_W-1:0]  prod
);
    import pfds_pkg::*;

    logic [MUL_W-1:0]     a_reg;
    logic [MUL_W-1:0]     b_reg;
    logic [MUL_W-1:0]     hi_reg;
    logic [MUL_W-1:0]     lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_W:0]       sum;

    // one multiplier bit per cycle, LSB first, product shifts right
    assign sum = {1'b0, hi_reg} + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            b_reg  <= req.b;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_W-1:1]};
            b_reg  <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

FILE: hdl/potential_field_drive_step_unit.sv
// Operation: an item passes through 12 products on the bit-serial multiplier,
//   a bit-serial modulo reduction of the angle, CORDIC_STEPS rotation steps
//   and single-step states for range reduction, rounding and clamping.
// Throughput: one item at a time; the next item is taken once the current
//   result sits in the output register.
// Reset: clears control, loads register defaults, goal = start goal, last
//   commands = 0.
module potential_field_drive_step_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pfds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfds_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [63:0]               repel_x,
    input  logic signed [63:0]               repel_y,
    input  logic                             repel_y_infinite,
    input  logic [31:0]                      elapsed_time,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               linear_command,
    output logic signed [31:0]               angular_command
);
    import pfds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M_LIN, S_M_ANG, S_MOD, S_RANGE, S_M_X, S_M_Y, S_CORD,
        S_ROUND, S_M_SQ, S_M_CUBE, S_M_AGAIN, S_M_RGAIN, S_DIFF, S_OUT
    } state_t;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (!v[64] && (|v[63:31]))
            r = 32'sh7FFFFFFF;
        else if (v[64] && !(&v[63:31]))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [63:0] gain_term(input logic [127:0] p,
                                                     input logic neg);
        logic [62:0] m;
        m = (|p[127:103]) ? '1 : p[102:40];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    state_t state_reg;

    logic [47:0]        att_lin_reg, att_ang_reg, rep_lin_reg, rep_ang_reg;
    logic [30:0]        lin_limit_reg, ang_limit_reg;
    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic signed [31:0] last_lin_reg, last_ang_reg;

    logic [63:0]        rx_mag_reg, ry_mag_reg;
    logic               rx_neg_reg, ry_neg_reg;
    logic [31:0]        dur_reg;

    logic [63:0]        theta_reg;
    logic               theta_neg_reg;
    logic [35:0]        rem_reg;
    logic signed [35:0] z_reg;
    logic               flip_reg;
    logic signed [51:0] x_reg, y_reg;
    logic [63:0]        work_reg;
    logic signed [63:0] term_a_reg, term_r_reg;
    logic signed [31:0] lin_res_reg, ang_res_reg;
    logic               axis_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               issued_reg;

    logic               out_valid_reg;
    logic signed [31:0] lin_out_reg, ang_out_reg;

    mul_req_t           mul_req;
    logic               mul_done;
    logic [127:0]       mul_prod;
    logic               is_mul;

    pfds_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    logic [31:0] g_sel, g_mag;
    logic        g_neg;
    assign g_sel = axis_reg ? goal_y_reg : goal_x_reg;
    assign g_neg = g_sel[31];
    assign g_mag = abs32(g_sel);

    always_comb
    begin
        mul_req.a = '0;
        mul_req.b = '0;
        is_mul    = 1'b0;
        unique case (state_reg)
            S_M_LIN:
            begin
                is_mul    = 1'b1;
                mul_req.a = {32'd0, abs32(last_lin_reg)};
                mul_req.b = {32'd0, dur_reg};
            end
            S_M_ANG:
            begin
                is_mul    = 1'b1;
                mul_req.a = {32'd0, abs32(last_ang_reg)};
                mul_req.b = {32'd0, dur_reg};
            end
            S_M_X:
            begin
                is_mul    = 1'b1;
                mul_req.a = {32'd0, abs32(goal_x_reg)};
                mul_req.b = {34'd0, INV_GAIN_Q30};
            end
            S_M_Y:
            begin
                is_mul    = 1'b1;
                mul_req.a = {32'd0, abs32(goal_y_reg)};
                mul_req.b = {34'd0, INV_GAIN_Q30};
            end
            S_M_SQ:
            begin
                is_mul    = 1'b1;
                mul_req.a = {32'd0, g_mag};
                mul_req.b = {32'd0, g_mag};
            end
            S_M_CUBE:
            begin
                is_mul    = 1'b1;
                mul_req.a = work_reg;
                mul_req.b = {32'd0, g_mag};
            end
            S_M_AGAIN:
            begin
                is_mul    = 1'b1;
                mul_req.a = {16'd0, axis_reg ? att_ang_reg : att_lin_reg};
                mul_req.b = work_reg;
            end
            S_M_RGAIN:
            begin
                is_mul    = 1'b1;
                mul_req.a = {16'd0, axis_reg ? rep_ang_reg : rep_lin_reg};
                mul_req.b = axis_reg ? ry_mag_reg : rx_mag_reg;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
        mul_req.start = is_mul && !issued_reg;
    end

    // translation
    logic signed [63:0] lin_prod_s, delta_s;
    logic signed [64:0] gx_trans;
    assign lin_prod_s = last_lin_reg[31] ? -$signed(mul_prod[63:0])
                                         : $signed(mul_prod[63:0]);
    assign delta_s    = lin_prod_s >>> 16;
    assign gx_trans   = $signed({{33{goal_x_reg[31]}}, goal_x_reg})
                      - $signed({delta_s[63], delta_s});

    // modulo 2*pi, one dividend bit per cycle
    logic [36:0] mod_t;
    logic [35:0] mod_next;
    assign mod_t    = {rem_reg, theta_reg[63]};
    assign mod_next = (mod_t >= TWO_PI_U) ? 36'(mod_t - TWO_PI_U) : mod_t[35:0];

    // angle range reduction
    logic signed [37:0] r0, r1, r2, r3, r3_sh;
    logic               flip_c;
    always_comb
    begin
        r0 = theta_neg_reg ? -$signed({2'b00, rem_reg}) : $signed({2'b00, rem_reg});
        r1 = (r0 > PI_Q32) ? r0 - TWO_PI_Q32 : r0;
        r2 = (r1 < -PI_Q32) ? r1 + TWO_PI_Q32 : r1;
        flip_c = 1'b0;
        r3 = r2;
        if (r2 > HALF_PI_Q32)
        begin
            r3 = r2 - PI_Q32;
            flip_c = 1'b1;
        end
        else if (r2 < -HALF_PI_Q32)
        begin
            r3 = r2 + PI_Q32;
            flip_c = 1'b1;
        end
        r3_sh = r3 >>> 2;
    end

    // prescale by 1/K
    logic [31:0]        pre_g;
    logic signed [63:0] pre_v, pre_sh;
    logic signed [51:0] pre_x;
    assign pre_g  = (state_reg == S_M_Y) ? goal_y_reg : goal_x_reg;
    assign pre_v  = pre_g[31] ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);
    assign pre_sh = pre_v >>> 14;
    assign pre_x  = flip_reg ? -pre_sh[51:0] : pre_sh[51:0];

    // CORDIC step
    logic [4:0]         cidx;
    logic signed [51:0] dx, dy;
    logic signed [35:0] atan_s;
    assign cidx   = step_reg[4:0];
    assign dx     = y_reg >>> cidx;
    assign dy     = x_reg >>> cidx;
    assign atan_s = $signed({4'd0, ATAN_Q30[cidx]});

    // rounding to Q16.16
    logic signed [51:0] xr, yr;
    assign xr = (x_reg + 52'sd32768) >>> 16;
    assign yr = (y_reg + 52'sd32768) >>> 16;

    // difference and clamp
    logic signed [64:0] d65;
    logic signed [63:0] d64, lim64, clamped;
    logic [30:0]        lim_sel;
    always_comb
    begin
        d65 = $signed({term_a_reg[63], term_a_reg}) - $signed({term_r_reg[63], term_r_reg});
        if (d65[64] != d65[63])
            d64 = d65[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
        else
            d64 = d65[63:0];
        lim_sel = axis_reg ? ang_limit_reg : lin_limit_reg;
        lim64   = $signed({33'd0, lim_sel});
        if (d64 >= lim64)
            clamped = lim64;
        else if (d64 <= -lim64)
            clamped = -lim64;
        else
            clamped = d64;
    end

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            att_lin_reg   <= RST_ATT_LIN;
            att_ang_reg   <= RST_ATT_ANG;
            rep_lin_reg   <= RST_REP_LIN;
            rep_ang_reg   <= RST_REP_ANG;
            lin_limit_reg <= RST_LIN_LIMIT;
            ang_limit_reg <= RST_ANG_LIMIT;
            goal_x_reg    <= RST_START_X;
            goal_y_reg    <= RST_START_Y;
            last_lin_reg  <= '0;
            last_ang_reg  <= '0;
            issued_reg    <= 1'b0;
            axis_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            lin_out_reg   <= '0;
            ang_out_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ATT_LIN:   att_lin_reg <= cfg_data;
                    CFG_ATT_ANG:   att_ang_reg <= cfg_data;
                    CFG_REP_LIN:   rep_lin_reg <= cfg_data;
                    CFG_REP_ANG:   rep_ang_reg <= cfg_data;
                    CFG_START_X:   goal_x_reg  <= cfg_data[31:0];
                    CFG_START_Y:   goal_y_reg  <= cfg_data[31:0];
                    CFG_LIN_LIMIT: lin_limit_reg <= cfg_data[30:0];
                    CFG_ANG_LIMIT: ang_limit_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end

            if (is_mul)
            begin
                if (mul_done)
                    issued_reg <= 1'b0;
                else
                    issued_reg <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        rx_neg_reg <= repel_x[63];
                        rx_mag_reg <= repel_x[63] ? (~repel_x + 1'b1) : repel_x;
                        if (repel_y_infinite)
                        begin
                            ry_neg_reg <= 1'b0;
                            ry_mag_reg <= INF_REPEL_Q16;
                        end
                        else
                        begin
                            ry_neg_reg <= repel_y[63];
                            ry_mag_reg <= repel_y[63] ? (~repel_y + 1'b1) : repel_y;
                        end
                        dur_reg   <= elapsed_time;
                        axis_reg  <= 1'b0;
                        state_reg <= S_M_LIN;
                    end
                end
                S_M_LIN:
                begin
                    if (mul_done)
                    begin
                        goal_x_reg <= sat32(gx_trans);
                        state_reg  <= S_M_ANG;
                    end
                end
                S_M_ANG:
                begin
                    if (mul_done)
                    begin
                        theta_reg     <= mul_prod[63:0];
                        theta_neg_reg <= !last_ang_reg[31] && (|mul_prod[63:0]);
                        rem_reg       <= '0;
                        step_reg      <= '0;
                        state_reg     <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    rem_reg   <= mod_next;
                    theta_reg <= theta_reg << 1;
                    step_reg  <= step_reg + 1'b1;
                    if (step_reg == '1)
                        state_reg <= S_RANGE;
                end
                S_RANGE:
                begin
                    z_reg     <= r3_sh[35:0];
                    flip_reg  <= flip_c;
                    state_reg <= S_M_X;
                end
                S_M_X:
                begin
                    if (mul_done)
                    begin
                        x_reg     <= pre_x;
                        state_reg <= S_M_Y;
                    end
                end
                S_M_Y:
                begin
                    if (mul_done)
                    begin
                        y_reg     <= pre_x;
                        step_reg  <= '0;
                        state_reg <= S_CORD;
                    end
                end
                S_CORD:
                begin
                    if (!z_reg[35])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_s;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_s;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    goal_x_reg <= sat32({{13{xr[51]}}, xr});
                    goal_y_reg <= sat32({{13{yr[51]}}, yr});
                    state_reg  <= S_M_SQ;
                end
                S_M_SQ:
                begin
                    if (mul_done)
                    begin
                        work_reg  <= mul_prod[63:0];
                        state_reg <= S_M_CUBE;
                    end
                end
                S_M_CUBE:
                begin
                    if (mul_done)
                    begin
                        work_reg  <= mul_prod[95:32];
                        state_reg <= S_M_AGAIN;
                    end
                end
                S_M_AGAIN:
                begin
                    if (mul_done)
                    begin
                        term_a_reg <= gain_term(mul_prod, g_neg);
                        state_reg  <= S_M_RGAIN;
                    end
                end
                S_M_RGAIN:
                begin
                    if (mul_done)
                    begin
                        term_r_reg <= gain_term(mul_prod, axis_reg ? ry_neg_reg : rx_neg_reg);
                        state_reg  <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    if (axis_reg)
                    begin
                        ang_res_reg <= clamped[31:0];
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        lin_res_reg <= clamped[31:0];
                        axis_reg    <= 1'b1;
                        state_reg   <= S_M_SQ;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        last_lin_reg  <= lin_res_reg;
                        last_ang_reg  <= ang_res_reg;
                        lin_out_reg   <= lin_res_reg;
                        ang_out_reg   <= ang_res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign linear_command  = lin_out_reg;
    assign angular_command = ang_out_reg;

    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside commit");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_M_LIN))
        else $error("accepted item did not start");

    a_lin_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (lin_out_reg <= $signed({1'b0, lin_limit_reg}))
                       && (lin_out_reg >= -$signed({1'b0, lin_limit_reg})))
        else $error("linear command beyond limit");

    a_mul_issue: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> is_mul && issued_reg)
        else $error("product done without request");

endmodule
